>>> rtl/infix_to_postfix_converter_assert.svh
// assertion macros used by the checker file
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ITP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// next-cycle implication, disabled during reset
`define ITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

>>> rtl/itp_pkg.sv
// shared types, constants and functions of the infix to postfix converter
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNMATCHED = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP
    } sym_class_t;

    typedef enum logic [1:0] {
        SEL_SYM,
        SEL_TOP,
        SEL_OVF,
        SEL_UNM
    } emit_sel_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_FLUSH,
        S_FIN
    } state_t;

    typedef struct packed {
        logic      latch;
        logic      push;
        logic      pop;
        logic      emit;
        emit_sel_t sel;
        logic      finish;
    } dp_cmd_t;

    typedef struct packed {
        sym_class_t cls;
        logic       last;
        logic       empty;
        logic       full;
        logic       top_open;
        logic       top_ge;
        logic       emit_ok;
        logic       out_free;
    } dp_status_t;

    function automatic sym_class_t classify(input logic [7:0] ch);
        sym_class_t c;
        c = CLS_OTHER;
        if (ch == CH_OPEN)
            c = CLS_OPEN;
        else if (ch == CH_CLOSE)
            c = CLS_CLOSE;
        else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_STAR ||
                 ch == CH_SLASH || ch == CH_CARET)
            c = CLS_OP;
        return c;
    endfunction

    function automatic logic [1:0] prec(input logic [7:0] ch);
        logic [1:0] p;
        p = 2'd0;
        if (ch == CH_CARET)
            p = 2'd2;
        else if (ch == CH_STAR || ch == CH_SLASH)
            p = 2'd1;
        return p;
    endfunction

endpackage

>>> rtl/infix_to_postfix_converter.sv
// Shunting-yard infix to postfix converter, one character per input beat.
// A plain character or a push is accepted in S_IDLE, then handled in S_WORK.
// Each operator popped adds an S_WORK step; a step handles one stack entry.
// On a last beat, S_FLUSH pops each stacked entry, then S_FIN sends the end beat.
// Results may wait in the output register; a full output stalls the work loop.
// Reset clears the state machine, stack count, hold valid and output valid; stack words are not cleared.
module infix_to_postfix_converter
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_symbol,
    output logic       symbol_valid,
    output logic       end_of_expression,
    output logic [1:0] error_code
);

    dp_cmd_t    cmd;
    dp_status_t status;

    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .symbol            (symbol),
        .last              (last),
        .cmd               (cmd),
        .status            (status),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_symbol        (out_symbol),
        .symbol_valid      (symbol_valid),
        .end_of_expression (end_of_expression),
        .error_code        (error_code)
    );

endmodule

>>> rtl/itp_datapath.sv
// operator stack, item latch, hold register and output register
module itp_datapath
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  symbol,
    input  logic        last,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_symbol,
    output logic        symbol_valid,
    output logic        end_of_expression,
    output logic [1:0]  error_code
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [7:0]    stack_mem [STACK_DEPTH];
    logic [7:0]    top_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    sym_reg;
    logic          last_reg;

    logic          pend_valid_reg, pend_valid_next;
    logic [7:0]    pend_sym_reg, pend_sym_next;
    logic          pend_sv_reg, pend_sv_next;
    logic [1:0]    pend_err_reg, pend_err_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_sym_reg, out_sym_next;
    logic          out_sv_reg, out_sv_next;
    logic          out_end_reg, out_end_next;
    logic [1:0]    out_err_reg, out_err_next;

    logic [7:0]    new_sym;
    logic          new_sv;
    logic [1:0]    new_err;
    logic [CW-1:0] rd_ptr;
    logic          out_free;

    assign out_free = !out_valid_reg || out_ready;

    // status toward the controller
    always_comb
    begin
        status.cls      = classify(sym_reg);
        status.last     = last_reg;
        status.empty    = (count_reg == '0);
        status.full     = (count_reg == CW'(STACK_DEPTH));
        status.top_open = (top_reg == CH_OPEN);
        status.top_ge   = (top_reg != CH_OPEN) && (prec(top_reg) >= prec(sym_reg));
        status.emit_ok  = last_reg ? (!pend_valid_reg || out_free) : out_free;
        status.out_free = out_free;
    end

    always_comb
    begin
        case (cmd.sel)
            SEL_SYM:
            begin
                new_sym = sym_reg;
                new_sv  = 1'b1;
                new_err = ERR_NONE;
            end
            SEL_TOP:
            begin
                new_sym = top_reg;
                new_sv  = 1'b1;
                new_err = ERR_NONE;
            end
            SEL_OVF:
            begin
                new_sym = 8'd0;
                new_sv  = 1'b0;
                new_err = ERR_OVERFLOW;
            end
            default:
            begin
                new_sym = 8'd0;
                new_sv  = 1'b0;
                new_err = ERR_UNMATCHED;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
            count_next = count_reg + CW'(1);
        else if (cmd.pop)
            count_next = count_reg - CW'(1);
        rd_ptr = count_next - CW'(1);
    end

    // results of a last item wait in the hold register, so the
    // final one can be tagged end of expression
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        pend_sv_next    = pend_sv_reg;
        pend_err_next   = pend_err_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_sym_next    = out_sym_reg;
        out_sv_next     = out_sv_reg;
        out_end_next    = out_end_reg;
        out_err_next    = out_err_reg;
        if (cmd.emit)
        begin
            if (!last_reg)
            begin
                out_valid_next = 1'b1;
                out_sym_next   = new_sym;
                out_sv_next    = new_sv;
                out_end_next   = 1'b0;
                out_err_next   = new_err;
            end
            else
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = pend_sym_reg;
                    out_sv_next    = pend_sv_reg;
                    out_end_next   = 1'b0;
                    out_err_next   = pend_err_reg;
                end
                pend_valid_next = 1'b1;
                pend_sym_next   = new_sym;
                pend_sv_next    = new_sv;
                pend_err_next   = new_err;
            end
        end
        else if (cmd.finish)
        begin
            out_valid_next  = 1'b1;
            out_end_next    = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_sym_next = pend_sym_reg;
                out_sv_next  = pend_sv_reg;
                out_err_next = pend_err_reg;
            end
            else
            begin
                out_sym_next = 8'd0;
                out_sv_next  = 1'b0;
                out_err_next = ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sym_reg  <= symbol;
            last_reg <= last;
        end
        pend_sym_reg <= pend_sym_next;
        pend_sv_reg  <= pend_sv_next;
        pend_err_reg <= pend_err_next;
        out_sym_reg  <= out_sym_next;
        out_sv_reg   <= out_sv_next;
        out_end_reg  <= out_end_next;
        out_err_reg  <= out_err_next;
    end

    // stack memory with a registered top-of-stack read, bypassed on push
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[count_reg[AW-1:0]] <= sym_reg;
            top_reg                      <= sym_reg;
        end
        else if (cmd.pop && count_next != '0)
        begin
            top_reg <= stack_mem[rd_ptr[AW-1:0]];
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_symbol        = out_sym_reg;
    assign symbol_valid      = out_sv_reg;
    assign end_of_expression = out_end_reg;
    assign error_code        = out_err_reg;

endmodule

>>> rtl/itp_ctrl.sv
// controller state machine of the infix to postfix converter
module itp_ctrl
    import itp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;
    state_t done_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_SYM;
        in_ready   = 1'b0;
        state_next = state_reg;
        done_state = status.last ? S_FLUSH : S_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                case (status.cls)
                    CLS_OPEN:
                    begin
                        if (!status.full)
                        begin
                            cmd.push   = 1'b1;
                            state_next = done_state;
                        end
                        else if (status.emit_ok)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.sel    = SEL_OVF;
                            state_next = done_state;
                        end
                    end
                    CLS_OP:
                    begin
                        // pop while stacked operator binds at least as tight
                        if (!status.empty && status.top_ge)
                        begin
                            if (status.emit_ok)
                            begin
                                cmd.emit = 1'b1;
                                cmd.sel  = SEL_TOP;
                                cmd.pop  = 1'b1;
                            end
                        end
                        else if (!status.full)
                        begin
                            cmd.push   = 1'b1;
                            state_next = done_state;
                        end
                        else if (status.emit_ok)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.sel    = SEL_OVF;
                            state_next = done_state;
                        end
                    end
                    CLS_CLOSE:
                    begin
                        if (status.empty)
                        begin
                            if (status.emit_ok)
                            begin
                                cmd.emit   = 1'b1;
                                cmd.sel    = SEL_UNM;
                                state_next = done_state;
                            end
                        end
                        else if (status.top_open)
                        begin
                            cmd.pop    = 1'b1;
                            state_next = done_state;
                        end
                        else if (status.emit_ok)
                        begin
                            cmd.emit = 1'b1;
                            cmd.sel  = SEL_TOP;
                            cmd.pop  = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (status.emit_ok)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.sel    = SEL_SYM;
                            state_next = done_state;
                        end
                    end
                endcase
            end
            S_FLUSH:
            begin
                // brackets left on the stack are dropped silently
                if (status.empty)
                    state_next = S_FIN;
                else if (status.top_open)
                    cmd.pop = 1'b1;
                else if (status.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_TOP;
                    cmd.pop  = 1'b1;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/itp_checker.sv
// port-level checker of the infix to postfix converter, bound to the top level
`include "infix_to_postfix_converter_assert.svh"

module itp_checker
    import itp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_symbol,
    input logic       symbol_valid,
    input logic       end_of_expression,
    input logic [1:0] error_code
);

    // a stalled result beat holds its payload
    `ITP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_symbol) && $stable(error_code) && $stable(end_of_expression))

    // markers carry no character
    `ITP_ASSERT_NOW(a_marker_zero, out_valid && !symbol_valid, out_symbol == 8'd0)

    // a character beat never reports an error
    `ITP_ASSERT_NOW(a_char_no_err, out_valid && symbol_valid, error_code == ERR_NONE)

    // only the defined error codes appear
    `ITP_ASSERT_NOW(a_err_code, out_valid, error_code == ERR_NONE || error_code == ERR_OVERFLOW || error_code == ERR_UNMATCHED)

    // an accepted input beat is followed by a work cycle
    `ITP_ASSERT_NEXT(a_in_gap, in_valid && in_ready, !in_ready)

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);
